/* design/tbrcd_pkg.sv */
// Shared types and constants for the two-button release chord detector.
package tbrcd_pkg;

    localparam int unsigned CountW = 8;
    localparam int unsigned TallyW = 4;
    localparam int unsigned NumButtons = 2;

    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
    localparam logic [TallyW-1:0] TallyMax = {TallyW{1'b1}};

    localparam logic [CountW-1:0] BounceReset = 8'd8;
    localparam logic [CountW-1:0] ChordReset = 8'd11;

    // Configuration register indexes
    localparam logic CFG_BOUNCE = 1'b0;
    localparam logic CFG_CHORD = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_PRESSED = 2'd1,
        MODE_RELEASED = 2'd2,
        MODE_FIRE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_CHORD = 2'd1,
        EV_FIRST = 2'd2,
        EV_SECOND = 2'd3
    } event_t;

    // Per-button machine state
    typedef struct packed {
        mode_t mode;
        logic [CountW-1:0] count;
    } lane_t;

    typedef struct packed {
        logic level_first;
        logic level_second;
    } in_req_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic [TallyW-1:0] secondary_count;
    } out_req_t;

endpackage

/* design/tbrcd_lane.sv */
// One button's debounce machine: next mode and tick counter for one sample.
module tbrcd_lane (
    input  tbrcd_pkg::lane_t cur,
    input  logic level,
    input  logic [tbrcd_pkg::CountW-1:0] bounce_ticks,
    input  logic [tbrcd_pkg::CountW-1:0] chord_ticks,
    output tbrcd_pkg::lane_t nxt
);

    logic [tbrcd_pkg::CountW-1:0] cnt_inc;
    logic bounce_ok;
    logic chord_ok;

    // Saturating tick increment and threshold compares
    assign cnt_inc = (cur.count == tbrcd_pkg::CountMax) ? cur.count
                                                        : cur.count + 1'b1;
    assign bounce_ok = cnt_inc > bounce_ticks;
    assign chord_ok = cnt_inc > chord_ticks;

    // Mode transitions; every move clears the counter
    always_comb
    begin
        nxt.mode = cur.mode;
        nxt.count = cnt_inc;
        unique case (cur.mode)
            tbrcd_pkg::MODE_IDLE:
            begin
                if (bounce_ok && level)
                begin
                    nxt.mode = tbrcd_pkg::MODE_PRESSED;
                    nxt.count = '0;
                end
            end
            tbrcd_pkg::MODE_PRESSED:
            begin
                if (bounce_ok && !level)
                begin
                    nxt.mode = tbrcd_pkg::MODE_RELEASED;
                    nxt.count = '0;
                end
            end
            tbrcd_pkg::MODE_RELEASED:
            begin
                if (chord_ok)
                begin
                    nxt.mode = tbrcd_pkg::MODE_FIRE;
                    nxt.count = '0;
                end
            end
            tbrcd_pkg::MODE_FIRE:
            begin
                nxt.mode = tbrcd_pkg::MODE_IDLE;
                nxt.count = '0;
            end
            default:
            begin
                nxt.mode = tbrcd_pkg::MODE_IDLE;
                nxt.count = '0;
            end
        endcase
    end

endmodule

/* design/tbrcd_merge.sv */
// Combines both button lanes into one event and updates the action tally.
module tbrcd_merge (
    input  tbrcd_pkg::lane_t lane0,
    input  tbrcd_pkg::lane_t lane1,
    input  logic [tbrcd_pkg::TallyW-1:0] tally,
    output tbrcd_pkg::lane_t lane0_out,
    output tbrcd_pkg::lane_t lane1_out,
    output logic [tbrcd_pkg::TallyW-1:0] tally_out,
    output tbrcd_pkg::event_t ev
);

    logic a_fire, b_fire, a_rel, b_rel;

    assign a_fire = lane0.mode == tbrcd_pkg::MODE_FIRE;
    assign b_fire = lane1.mode == tbrcd_pkg::MODE_FIRE;
    assign a_rel = lane0.mode == tbrcd_pkg::MODE_RELEASED;
    assign b_rel = lane1.mode == tbrcd_pkg::MODE_RELEASED;

    // Chord wins over single-button actions; counters are always kept
    always_comb
    begin
        lane0_out = lane0;
        lane1_out = lane1;
        tally_out = tally;
        ev = tbrcd_pkg::EV_NONE;
        priority if ((a_fire && (b_rel || b_fire)) || (b_fire && a_rel))
        begin
            ev = tbrcd_pkg::EV_CHORD;
            lane0_out.mode = tbrcd_pkg::MODE_IDLE;
            lane1_out.mode = tbrcd_pkg::MODE_IDLE;
        end
        else if (a_fire)
        begin
            ev = tbrcd_pkg::EV_FIRST;
            tally_out = '0;
            lane1_out.mode = tbrcd_pkg::MODE_IDLE;
        end
        else if (b_fire)
        begin
            ev = tbrcd_pkg::EV_SECOND;
            if (tally != tbrcd_pkg::TallyMax)
                tally_out = tally + 1'b1;
            lane0_out.mode = tbrcd_pkg::MODE_IDLE;
        end
        else
        begin
            ev = tbrcd_pkg::EV_NONE;
        end
    end

endmodule

/* design/two_button_release_chord_detector.sv */
// Top level: button lanes, merge stage, state registers and output buffer.
//
// Usage: each input request is one sample tick carrying the raw levels of
// two buttons (level_first, level_second). Every accepted request gives
// exactly one output request with event_res (none, chord, button 0 action,
// button 1 action) and secondary_count (button 1 actions since the last
// button 0 action, saturating at 15).
// Channels use valid/stall; a request moves when valid is high and stall
// is low. The configuration port writes bounce_ticks (index 0) and
// chord_ticks (index 1) whenever cfg_we is high.
// Timing: a result is registered in the output register when that is free,
// else in the skid register. Throughput: one sample per cycle while in_stall
// is low; the lanes and merge are combinational from the state registers.
// When the receiver stalls, a second result is held in a skid register and
// in_stall rises only once that register is full; in_stall is a register
// output and does not depend on out_stall.
// Reset: both buttons idle, tick counters and tally zero, thresholds 8 and
// 11, output and skid registers empty.
module two_button_release_chord_detector (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  tbrcd_pkg::in_req_t in_req,
    output logic out_valid,
    input  logic out_stall,
    output tbrcd_pkg::out_req_t out_req,
    input  logic cfg_we,
    input  logic cfg_index,
    input  logic [tbrcd_pkg::CountW-1:0] cfg_data
);

    logic [tbrcd_pkg::CountW-1:0] bounce_reg;
    logic [tbrcd_pkg::CountW-1:0] chord_reg;
    tbrcd_pkg::lane_t lane_reg [tbrcd_pkg::NumButtons];
    tbrcd_pkg::lane_t lane_step [tbrcd_pkg::NumButtons];
    tbrcd_pkg::lane_t lane_next [tbrcd_pkg::NumButtons];
    logic [tbrcd_pkg::TallyW-1:0] tally_reg;
    logic [tbrcd_pkg::TallyW-1:0] tally_next;
    tbrcd_pkg::event_t ev;
    logic [tbrcd_pkg::NumButtons-1:0] levels;

    tbrcd_pkg::out_req_t out_reg;
    logic out_valid_reg;
    tbrcd_pkg::out_req_t skid_reg;
    logic skid_valid_reg;
    tbrcd_pkg::out_req_t res_next;

    logic accept;
    logic take;

    assign levels = {in_req.level_second, in_req.level_first};
    assign accept = in_valid && !skid_valid_reg;
    assign take = out_valid_reg && !out_stall;

    // One lane per button
    for (genvar k = 0; k < tbrcd_pkg::NumButtons; k++)
    begin : g_lane
        tbrcd_lane u_lane (
            .cur          (lane_reg[k]),
            .level        (levels[k]),
            .bounce_ticks (bounce_reg),
            .chord_ticks  (chord_reg),
            .nxt          (lane_step[k])
        );
    end

    // Event decision across the lanes
    tbrcd_merge u_merge (
        .lane0     (lane_step[0]),
        .lane1     (lane_step[1]),
        .tally     (tally_reg),
        .lane0_out (lane_next[0]),
        .lane1_out (lane_next[1]),
        .tally_out (tally_next),
        .ev        (ev)
    );

    assign res_next.event_res = ev;
    assign res_next.secondary_count = tally_next;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounce_reg <= tbrcd_pkg::BounceReset;
            chord_reg <= tbrcd_pkg::ChordReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tbrcd_pkg::CFG_BOUNCE: bounce_reg <= cfg_data;
                tbrcd_pkg::CFG_CHORD:  chord_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Button and tally state, advanced once per accepted sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < tbrcd_pkg::NumButtons; k++)
            begin
                lane_reg[k].mode <= tbrcd_pkg::MODE_IDLE;
                lane_reg[k].count <= '0;
            end
            tally_reg <= '0;
        end
        else if (accept)
        begin
            for (int k = 0; k < tbrcd_pkg::NumButtons; k++)
                lane_reg[k] <= lane_next[k];
            tally_reg <= tally_next;
        end
    end

    // Output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= res_next;
        end
        else if (accept)
        begin
            skid_reg <= res_next;
        end
    end

    assign in_stall = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_req = out_reg;

endmodule

/* test/two_button_release_chord_detector_tb.sv */
// Self-checking testbench for the two-button release chord detector.
module two_button_release_chord_detector_tb;

    // Stimulus segment kinds
    typedef enum int {
        GEST_CHORD,
        GEST_FIRST,
        GEST_SECOND,
        GEST_GLITCH,
        GEST_NOISE
    } gesture_t;

    // Predicts detector events and holds the results still to come
    class chord_scoreboard;
        tbrcd_pkg::mode_t btn_mode [tbrcd_pkg::NumButtons];
        logic [tbrcd_pkg::CountW-1:0] btn_ticks [tbrcd_pkg::NumButtons];
        logic [tbrcd_pkg::TallyW-1:0] tally;
        logic [tbrcd_pkg::CountW-1:0] bounce_thr;
        logic [tbrcd_pkg::CountW-1:0] chord_thr;
        tbrcd_pkg::out_req_t expected_events [$];
        int errors;

        function new();
            for (int k = 0; k < tbrcd_pkg::NumButtons; k++)
            begin
                btn_mode[k] = tbrcd_pkg::MODE_IDLE;
                btn_ticks[k] = '0;
            end
            tally = '0;
            bounce_thr = tbrcd_pkg::BounceReset;
            chord_thr = tbrcd_pkg::ChordReset;
            errors = 0;
        endfunction

        function void write_reg(logic idx, logic [tbrcd_pkg::CountW-1:0] value);
            if (idx == tbrcd_pkg::CFG_BOUNCE)
                bounce_thr = value;
            else
                chord_thr = value;
        endfunction

        // One tick of a single button's debounce machine
        function void advance_button(int k, logic level);
            if (btn_mode[k] == tbrcd_pkg::MODE_FIRE)
            begin
                btn_mode[k] = tbrcd_pkg::MODE_IDLE;
                btn_ticks[k] = '0;
                return;
            end
            if (btn_ticks[k] != tbrcd_pkg::CountMax)
                btn_ticks[k] = btn_ticks[k] + 1'b1;
            case (btn_mode[k])
                tbrcd_pkg::MODE_IDLE:
                begin
                    if (btn_ticks[k] > bounce_thr && level)
                    begin
                        btn_mode[k] = tbrcd_pkg::MODE_PRESSED;
                        btn_ticks[k] = '0;
                    end
                end
                tbrcd_pkg::MODE_PRESSED:
                begin
                    if (btn_ticks[k] > bounce_thr && !level)
                    begin
                        btn_mode[k] = tbrcd_pkg::MODE_RELEASED;
                        btn_ticks[k] = '0;
                    end
                end
                default:
                begin
                    if (btn_ticks[k] > chord_thr)
                    begin
                        btn_mode[k] = tbrcd_pkg::MODE_FIRE;
                        btn_ticks[k] = '0;
                    end
                end
            endcase
        endfunction

        function void note_input(tbrcd_pkg::in_req_t req);
            tbrcd_pkg::event_t ev;
            tbrcd_pkg::mode_t m0;
            tbrcd_pkg::mode_t m1;
            tbrcd_pkg::out_req_t res;
            advance_button(0, req.level_first);
            advance_button(1, req.level_second);
            m0 = btn_mode[0];
            m1 = btn_mode[1];
            ev = tbrcd_pkg::EV_NONE;
            // chord wins over single actions
            if ((m0 == tbrcd_pkg::MODE_FIRE &&
                 (m1 == tbrcd_pkg::MODE_RELEASED || m1 == tbrcd_pkg::MODE_FIRE)) ||
                (m1 == tbrcd_pkg::MODE_FIRE && m0 == tbrcd_pkg::MODE_RELEASED))
            begin
                ev = tbrcd_pkg::EV_CHORD;
                btn_mode[0] = tbrcd_pkg::MODE_IDLE;
                btn_mode[1] = tbrcd_pkg::MODE_IDLE;
            end
            else if (m0 == tbrcd_pkg::MODE_FIRE)
            begin
                ev = tbrcd_pkg::EV_FIRST;
                tally = '0;
                btn_mode[1] = tbrcd_pkg::MODE_IDLE;
            end
            else if (m1 == tbrcd_pkg::MODE_FIRE)
            begin
                ev = tbrcd_pkg::EV_SECOND;
                if (tally != tbrcd_pkg::TallyMax)
                    tally = tally + 1'b1;
                btn_mode[0] = tbrcd_pkg::MODE_IDLE;
            end
            res.event_res = ev;
            res.secondary_count = tally;
            expected_events = {expected_events, res};
        endfunction

        task report(string msg);
            if (errors < 64)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(tbrcd_pkg::out_req_t got);
            tbrcd_pkg::out_req_t want;
            if (expected_events.size() == 0)
            begin
                report($sformatf("result with none pending: event %0d count %0d",
                    got.event_res, got.secondary_count));
                return;
            end
            want = expected_events.pop_front();
            if (got.event_res !== want.event_res)
                report($sformatf("event_res got %0d want %0d", got.event_res,
                    want.event_res));
            if (got.secondary_count !== want.secondary_count)
                report($sformatf("secondary_count got %0d want %0d",
                    got.secondary_count, want.secondary_count));
        endtask

        function int pending();
            return expected_events.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    tbrcd_pkg::in_req_t in_req = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    tbrcd_pkg::out_req_t out_req;
    logic cfg_we = 1'b0;
    logic cfg_index = tbrcd_pkg::CFG_BOUNCE;
    logic [tbrcd_pkg::CountW-1:0] cfg_data = '0;

    chord_scoreboard sb = new();

    logic [tbrcd_pkg::CountW-1:0] cur_bounce = tbrcd_pkg::BounceReset;
    logic [tbrcd_pkg::CountW-1:0] cur_chord = tbrcd_pkg::ChordReset;
    int items_sent = 0;
    int hold_cycles = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    bit final_part = 1'b0;

    // {level_first, level_second} per tick, for thresholds of zero
    logic [1:0] directed_ticks [0:23] = '{
        2'b11, 2'b00, 2'b00, 2'b00,
        2'b10, 2'b00, 2'b00, 2'b00,
        2'b01, 2'b00, 2'b00, 2'b00,
        2'b01, 2'b00, 2'b00, 2'b00,
        2'b10, 2'b01, 2'b00, 2'b00,
        2'b11, 2'b11, 2'b00, 2'b00
    };

    two_button_release_chord_detector dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_req(in_req),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_req(out_req),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Handshake monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_input(in_req);
            if (out_valid && !out_stall)
                sb.check_result(out_req);
        end
    end

    // Receiver: random stall bursts, plus a long hold-off on request
    initial
    begin : receiver
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                n = hold_cycles;
                hold_cycles = 0;
            end
            else if (!rx_calm && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                n = $urandom_range(1, 5);
            end
            else
            begin
                out_stall <= 1'b0;
                n = rx_calm ? 1 : $urandom_range(1, 10);
            end
            repeat (n - 1) @(posedge clk);
        end
    end

    // Offer one tick and wait for it to be taken, then maybe idle a little
    task automatic send_tick(tbrcd_pkg::in_req_t r);
        in_valid <= 1'b1;
        in_req <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (!tx_calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every pending result has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_thresholds(logic [tbrcd_pkg::CountW-1:0] b,
                                    logic [tbrcd_pkg::CountW-1:0] c);
        cfg_we <= 1'b1;
        cfg_index <= tbrcd_pkg::CFG_BOUNCE;
        cfg_data <= b;
        @(posedge clk);
        cfg_index <= tbrcd_pkg::CFG_CHORD;
        cfg_data <= c;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(tbrcd_pkg::CFG_BOUNCE, b);
        sb.write_reg(tbrcd_pkg::CFG_CHORD, c);
        cur_bounce = b;
        cur_chord = c;
    endtask

    // Press/release pattern sized from the current thresholds
    task automatic gesture(gesture_t kind);
        int press_w;
        int tail_w;
        int lead0;
        int lead1;
        int len0;
        int len1;
        int total;
        tbrcd_pkg::in_req_t r;
        press_w = (cur_bounce > 12) ? 12 : int'(cur_bounce);
        tail_w = press_w + ((cur_chord > 14) ? 14 : int'(cur_chord)) + $urandom_range(2, 6);
        lead0 = 0;
        lead1 = 0;
        len0 = 0;
        len1 = 0;
        case (kind)
            GEST_CHORD:
            begin
                lead0 = $urandom_range(0, 2);
                lead1 = $urandom_range(0, 2);
                len0 = press_w + 1 + $urandom_range(0, 4);
                len1 = press_w + 1 + $urandom_range(0, 4);
            end
            GEST_FIRST:
                len0 = press_w + 1 + $urandom_range(0, 4);
            GEST_SECOND:
                len1 = press_w + 1 + $urandom_range(0, 4);
            GEST_GLITCH:
            begin
                lead1 = $urandom_range(0, 2);
                len0 = $urandom_range(0, press_w);
                len1 = $urandom_range(0, press_w);
                tail_w = $urandom_range(1, press_w + 2);
            end
            default:
                ;
        endcase
        total = ((lead0 + len0 > lead1 + len1) ? lead0 + len0 : lead1 + len1) + tail_w;
        if (kind == GEST_NOISE)
            total = $urandom_range(1, 8);
        for (int t = 0; t < total; t++)
        begin
            if (kind == GEST_NOISE)
                r = tbrcd_pkg::in_req_t'(2'($urandom_range(0, 3)));
            else
            begin
                r.level_first = (t >= lead0) && (t < lead0 + len0);
                r.level_second = (t >= lead1) && (t < lead1 + len1);
            end
            send_tick(r);
        end
    endtask

    // One threshold setting: mostly clean gestures, some glitches and noise
    task automatic run_phase(logic [tbrcd_pkg::CountW-1:0] b,
                             logic [tbrcd_pkg::CountW-1:0] c, int items,
                             bit hold, bit pause);
        int pick;
        bit mid_done;
        drain();
        write_thresholds(b, c);
        items_sent = 0;
        mid_done = 1'b0;
        while (items_sent < items)
        begin
            if (!mid_done && items_sent >= items / 2)
            begin
                mid_done = 1'b1;
                if (hold)
                begin
                    // receiver holds off while the sender keeps pushing
                    hold_cycles = 50;
                    tx_calm = 1'b1;
                    repeat (24)
                        send_tick(tbrcd_pkg::in_req_t'(2'($urandom_range(0, 3))));
                end
                if (pause)
                    drain();
            end
            tx_calm = final_part || ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 30)
                gesture(GEST_CHORD);
            else if (pick < 50)
                gesture(GEST_FIRST);
            else if (pick < 70)
                gesture(GEST_SECOND);
            else if (pick < 76)
            begin
                // long run of button 1 actions drives the tally to saturation
                repeat ($urandom_range(16, 20)) gesture(GEST_SECOND);
            end
            else if (pick < 90)
                gesture(GEST_GLITCH);
            else
                gesture(GEST_NOISE);
        end
    endtask

    initial
    begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero thresholds, chords, single actions, all level pairs
        write_thresholds('0, '0);
        tx_calm = 1'b0;
        foreach (directed_ticks[i])
            send_tick(tbrcd_pkg::in_req_t'(directed_ticks[i]));

        run_phase(8'd8, 8'd11, 300, 1'b0, 1'b0);
        run_phase(8'd3, 8'd5, 300, 1'b1, 1'b0);
        run_phase(8'd0, tbrcd_pkg::CountMax, 200, 1'b0, 1'b1);
        run_phase(tbrcd_pkg::CountMax, 8'd0, 300, 1'b0, 1'b0);
        run_phase(8'd1, 8'd1, 300, 1'b0, 1'b1);
        run_phase(tbrcd_pkg::CountMax, tbrcd_pkg::CountMax, 150, 1'b0, 1'b0);

        // last part: no idling on either side
        final_part = 1'b1;
        rx_calm = 1'b1;
        run_phase(8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)), 300,
                  1'b0, 1'b0);

        drain();
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
            $display("[two_button_release_chord_detector] OK");
        else
            $display("[two_button_release_chord_detector] ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("[two_button_release_chord_detector] ERROR");
        $finish;
    end

endmodule
